// ===== design/i2p_pkg.sv =====
package i2p_pkg;

	localparam int CharW = 8;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNMATCH  = 2'd2;
	localparam logic [1:0] ST_IGNORED  = 2'd3;

	// Characters with a meaning of their own
	localparam logic [CharW-1:0] CH_POW   = 8'h5E;
	localparam logic [CharW-1:0] CH_MUL   = 8'h2A;
	localparam logic [CharW-1:0] CH_DIV   = 8'h2F;
	localparam logic [CharW-1:0] CH_ADD   = 8'h2B;
	localparam logic [CharW-1:0] CH_SUB   = 8'h2D;
	localparam logic [CharW-1:0] CH_OPEN  = 8'h28;
	localparam logic [CharW-1:0] CH_CLOSE = 8'h29;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORK,
		S_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		C_LETTER,
		C_OPEN,
		C_CLOSE,
		C_OPER,
		C_OTHER
	} cls_t;

	// Command to the stack row
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	// View of the stack row
	typedef struct packed {
		logic [CharW-1:0] top;
		logic [CharW-1:0] next;
		logic             empty;
		logic             full;
		logic             one_left;
	} stk_stat_t;

	// Precedence: 3 for ^, 2 for * and /, 1 for + and -, 0 for anything else
	function automatic logic [1:0] prec_of(input logic [CharW-1:0] ch);
		logic [1:0] p;
		p = 2'd0;
		if (ch == CH_POW) p = 2'd3;
		else if (ch == CH_MUL || ch == CH_DIV) p = 2'd2;
		else if (ch == CH_ADD || ch == CH_SUB) p = 2'd1;
		return p;
	endfunction

	function automatic cls_t classify(input logic [CharW-1:0] ch);
		cls_t c;
		if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)) c = C_LETTER;
		else if (ch == CH_OPEN) c = C_OPEN;
		else if (ch == CH_CLOSE) c = C_CLOSE;
		else if (prec_of(ch) != 2'd0) c = C_OPER;
		else c = C_OTHER;
		return c;
	endfunction

endpackage

// ===== design/i2p_cell.sv =====
module i2p_cell (
	input  logic                    clk,
	input  i2p_pkg::stk_cmd_t       cmd,
	input  logic [i2p_pkg::CharW-1:0] from_above,
	input  logic [i2p_pkg::CharW-1:0] from_below,
	output logic [i2p_pkg::CharW-1:0] data
);
	import i2p_pkg::*;

	logic [CharW-1:0] data_q;

	// Shift down on push, up on pop, else hold
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			data_q <= from_above;
		end else if (cmd.pop) begin
			data_q <= from_below;
		end
	end

	assign data = data_q;

endmodule

// ===== design/i2p_stack.sv =====
module i2p_stack #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  i2p_pkg::stk_cmd_t         cmd,
	input  logic [i2p_pkg::CharW-1:0] push_data,
	output i2p_pkg::stk_stat_t        stat
);
	import i2p_pkg::*;

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CharW-1:0] cell_d [DEPTH];
	logic [CntW-1:0]  count_q;

	// Row of cells, top of stack at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [CharW-1:0] above;
		logic [CharW-1:0] below;
		if (i == 0) begin : g_top
			assign above = push_data;
		end else begin : g_mid
			assign above = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = cell_d[i];
		end else begin : g_up
			assign below = cell_d[i+1];
		end
		i2p_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.from_above (above),
			.from_below (below),
			.data       (cell_d[i])
		);
	end

	// Track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CntW'(1);
		end
	end

	assign stat.top      = cell_d[0];
	assign stat.next     = cell_d[1];
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CntW'(DEPTH));
	assign stat.one_left = (count_q == CntW'(1));

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// Infix to postfix converter (shunting-yard).
// Input channel item_valid/item_ready carries one ASCII character (char_in)
// and end_of_expr, set on the final character of an expression. Output
// channel result_valid/result_ready carries out_char, out_none, out_last and
// status; out_last marks the final result caused by one input character.
// Operators wait in a row of stack cells that shift down on push and up on
// pop, so the top two entries are always at fixed places.
// A character is taken only in idle; the sequencer then works in stack steps
// (a push, a pop, or a status result): one for a letter or a plain push, and
// an operator first pops each entry of equal or higher precedence. With
// end_of_expr set, the flush pops each stacked entry and then gives the end
// result. Each pop is one shift of the cell row. Results go to a result
// register. A stalled receiver holds it and freezes the sequencer while it
// has a result to emit; a new character is taken while the last result still
// waits, once the sequencer is back in idle.
// Reset empties the stack and the result register; stack contents are not
// cleared.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [i2p_pkg::CharW-1:0] char_in,
	input  logic                      end_of_expr,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [i2p_pkg::CharW-1:0] out_char,
	output logic                      out_none,
	output logic                      out_last,
	output logic [1:0]                status
);
	import i2p_pkg::*;

	state_t           state_q, state_d;
	cls_t             cls_q;
	logic [CharW-1:0] ch_q;
	logic             last_q;
	logic [1:0]       endst_q, endst_d;

	stk_cmd_t         want_cmd, cmd;
	stk_stat_t        stat;

	logic             em_valid;
	logic [CharW-1:0] em_char;
	logic             em_none;
	logic             em_last;
	logic [1:0]       em_status;
	logic             can_emit, go, em_fire;
	state_t           want_state;
	logic [1:0]       want_endst;
	logic [1:0]       p_in;

	logic             ov_q;
	logic [CharW-1:0] oc_q;
	logic             on_q;
	logic             ol_q;
	logic [1:0]       os_q;

	i2p_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_data (ch_q),
		.stat      (stat)
	);

	assign item_ready = (state_q == S_IDLE);
	assign can_emit   = !ov_q || result_ready;
	assign p_in       = prec_of(ch_q);

	// Next step of the sequencer and the result it emits
	always_comb begin
		want_cmd   = '0;
		want_state = state_q;
		want_endst = endst_q;
		em_valid   = 1'b0;
		em_char    = '0;
		em_none    = 1'b0;
		em_last    = 1'b0;
		em_status  = ST_OK;
		case (state_q)
			S_IDLE: begin
				want_state = S_IDLE;
			end
			S_WORK: begin
				want_state = last_q ? S_FLUSH : S_IDLE;
				case (cls_q)
					C_LETTER: begin
						em_valid = 1'b1;
						em_char  = ch_q;
						em_last  = !last_q;
					end
					C_OPEN: begin
						if (stat.full) begin
							em_valid  = 1'b1;
							em_none   = 1'b1;
							em_last   = !last_q;
							em_status = ST_OVERFLOW;
						end else begin
							want_cmd.push = 1'b1;
						end
					end
					C_CLOSE: begin
						if (stat.empty) begin
							em_valid  = 1'b1;
							em_none   = 1'b1;
							em_last   = !last_q;
							em_status = ST_UNMATCH;
						end else if (stat.top == CH_OPEN) begin
							want_cmd.pop = 1'b1;
						end else begin
							want_cmd.pop = 1'b1;
							em_valid     = 1'b1;
							em_char      = stat.top;
							em_last      = !last_q && !stat.one_left
							               && (stat.next == CH_OPEN);
							want_state   = S_WORK;
						end
					end
					C_OPER: begin
						if (!stat.empty && (p_in <= prec_of(stat.top))) begin
							want_cmd.pop = 1'b1;
							em_valid     = 1'b1;
							em_char      = stat.top;
							em_last      = !last_q && (stat.one_left
							               || (prec_of(stat.next) < p_in));
							want_state   = S_WORK;
						end else if (stat.full) begin
							em_valid  = 1'b1;
							em_none   = 1'b1;
							em_last   = !last_q;
							em_status = ST_OVERFLOW;
						end else begin
							want_cmd.push = 1'b1;
						end
					end
					default: begin
						em_valid  = 1'b1;
						em_none   = 1'b1;
						em_last   = !last_q;
						em_status = ST_IGNORED;
					end
				endcase
			end
			S_FLUSH: begin
				if (stat.empty) begin
					em_valid   = 1'b1;
					em_none    = 1'b1;
					em_last    = 1'b1;
					em_status  = endst_q;
					want_state = S_IDLE;
				end else if (stat.top == CH_OPEN) begin
					want_cmd.pop = 1'b1;
					want_endst   = ST_UNMATCH;
				end else begin
					want_cmd.pop = 1'b1;
					em_valid     = 1'b1;
					em_char      = stat.top;
				end
			end
			default: begin
				want_state = S_IDLE;
			end
		endcase

		// Hold everything while a result cannot be placed
		go      = !em_valid || can_emit;
		em_fire = em_valid && can_emit;
		cmd     = go ? want_cmd : '0;
		state_d = go ? want_state : state_q;
		endst_d = go ? want_endst : endst_q;
		if (item_valid && item_ready) begin
			state_d = S_WORK;
			endst_d = ST_OK;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			endst_q <= ST_OK;
		end else begin
			state_q <= state_d;
			endst_q <= endst_d;
		end
	end

	// Capture the character on transfer
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ch_q   <= char_in;
			last_q <= end_of_expr;
			cls_q  <= classify(char_in);
		end
	end

	// Result register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (em_fire) begin
			ov_q <= 1'b1;
		end else if (result_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_fire) begin
			oc_q <= em_char;
			on_q <= em_none;
			ol_q <= em_last;
			os_q <= em_status;
		end
	end

	assign result_valid = ov_q;
	assign out_char     = oc_q;
	assign out_none     = on_q;
	assign out_last     = ol_q;
	assign status       = os_q;

`ifndef NO_ASSERTIONS
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("stack pushed and popped in one cycle");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push onto a full stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop from an empty stack");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !out_none) |-> (status == ST_OK))
		else $error("character result with nonzero status");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import i2p_pkg::*;

	localparam int DEPTH       = 16;
	localparam int GAP_MAX     = 19;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_ITEMS  = 480;
	localparam int MAX_SHOWN   = 10;
	localparam int DRAIN_CYC   = 40;

	typedef struct {
		logic [CharW-1:0] ch;
		logic             none;
		logic             last;
		logic [1:0]       st;
	} postfix_res_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	logic [CharW-1:0] char_in;
	logic             end_of_expr;
	logic             result_valid;
	logic             result_ready;
	logic [CharW-1:0] out_char;
	logic             out_none;
	logic             out_last;
	logic [1:0]       status;

	// Shadow operator stack and the postfix results still owed by the block
	logic [CharW-1:0] op_stk [DEPTH];
	int               op_cnt = 0;
	postfix_res_t     postfix_q [$];
	logic [CharW-1:0] expr_buf [$];

	int gap_max;
	int stall_max;
	int err_cnt = 0;
	int rand_sent = 0;
	int quiet_cyc = 0;

	infix_to_postfix_converter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.char_in     (char_in),
		.end_of_expr (end_of_expr),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_char    (out_char),
		.out_none    (out_none),
		.out_last    (out_last),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int op_rank(input logic [CharW-1:0] ch);
		int r;
		r = 0;
		if (ch == CH_POW) r = 3;
		else if (ch == CH_MUL || ch == CH_DIV) r = 2;
		else if (ch == CH_ADD || ch == CH_SUB) r = 1;
		return r;
	endfunction

	function automatic bit is_letter(input logic [CharW-1:0] ch);
		return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
	endfunction

	function automatic void push_result(input logic [CharW-1:0] ch, input logic none,
			input logic [1:0] st);
		postfix_res_t r;
		r.ch   = ch;
		r.none = none;
		r.last = 1'b0;
		r.st   = st;
		postfix_q.push_back(r);
	endfunction

	function automatic void push_operator(input logic [CharW-1:0] ch);
		if (op_cnt < DEPTH) begin
			op_stk[op_cnt] = ch;
			op_cnt++;
		end else begin
			push_result('0, 1'b1, ST_OVERFLOW);
		end
	endfunction

	// Queue the results that one character causes, shunting-yard style
	function automatic void predict_postfix(input logic [CharW-1:0] ch, input logic eoe);
		int         first;
		bit         found;
		logic [1:0] end_st;
		first  = postfix_q.size();
		found  = 1'b0;
		end_st = ST_OK;
		if (is_letter(ch)) begin
			push_result(ch, 1'b0, ST_OK);
		end else if (ch == CH_OPEN) begin
			push_operator(ch);
		end else if (ch == CH_CLOSE) begin
			// pop down to the matching open; a missing one empties the stack
			while (op_cnt > 0 && !found) begin
				op_cnt--;
				if (op_stk[op_cnt] == CH_OPEN) found = 1'b1;
				else push_result(op_stk[op_cnt], 1'b0, ST_OK);
			end
			if (!found) push_result('0, 1'b1, ST_UNMATCH);
		end else if (op_rank(ch) > 0) begin
			while (op_cnt > 0 && op_rank(ch) <= op_rank(op_stk[op_cnt-1])) begin
				op_cnt--;
				push_result(op_stk[op_cnt], 1'b0, ST_OK);
			end
			push_operator(ch);
		end else begin
			push_result('0, 1'b1, ST_IGNORED);
		end
		// flush; an open left on the stack is dropped and marks the end result
		if (eoe) begin
			while (op_cnt > 0) begin
				op_cnt--;
				if (op_stk[op_cnt] == CH_OPEN) end_st = ST_UNMATCH;
				else push_result(op_stk[op_cnt], 1'b0, ST_OK);
			end
			push_result('0, 1'b1, end_st);
		end
		if (postfix_q.size() > first) postfix_q[postfix_q.size()-1].last = 1'b1;
	endfunction

	function automatic void flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN) $display("%s", msg);
	endfunction

	// Send one character: idle for a random gap, then hold valid until the transfer
	task automatic send_char(input logic [CharW-1:0] ch, input logic eoe);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		char_in     <= ch;
		end_of_expr <= eoe;
		do @(posedge clk); while (item_ready !== 1'b1);
		predict_postfix(ch, eoe);
	endtask

	// Send the buffered characters, marking the last one as end of expression if asked
	task automatic send_buf(input bit close_expr);
		for (int i = 0; i < expr_buf.size(); i++) begin
			send_char(expr_buf[i], close_expr && (i == expr_buf.size() - 1));
			rand_sent++;
		end
		expr_buf.delete();
	endtask

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
	endfunction

	function automatic logic [CharW-1:0] rand_letter();
		logic [CharW-1:0] base;
		base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
		return base + CharW'($urandom_range(0, 25));
	endfunction

	function automatic logic [CharW-1:0] rand_oper();
		logic [CharW-1:0] op;
		case ($urandom_range(0, 4))
			0: op = CH_POW;
			1: op = CH_MUL;
			2: op = CH_DIV;
			3: op = CH_ADD;
			default: op = CH_SUB;
		endcase
		return op;
	endfunction

	// Append a well-formed expression with random letters, operators and nesting
	function automatic void build_expr(input int terms);
		int depth;
		depth = 0;
		for (int i = 0; i < terms; i++) begin
			while (depth < 4 && $urandom_range(0, 3) == 0) begin
				expr_buf.push_back(CH_OPEN);
				depth++;
			end
			expr_buf.push_back(rand_letter());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				expr_buf.push_back(CH_CLOSE);
				depth--;
			end
			if (i < terms - 1) expr_buf.push_back(rand_oper());
		end
		repeat (depth) expr_buf.push_back(CH_CLOSE);
	endfunction

	// Letters at the range edges, their neighbors, and the byte extremes
	task automatic test_char_classes();
		expr_buf.push_back(8'h00);
		append_text("@AZ[`az{");
		expr_buf.push_back(8'hFF);
		send_buf(1'b1);
	endtask

	// All operators, left association of equal ranks, nested group
	task automatic test_precedence();
		append_text("a^b^c*(d-e)/f+g");
		send_buf(1'b1);
	endtask

	// Close with nothing open, then an open left at the flush
	task automatic test_unmatched_parens();
		send_char(CH_CLOSE, 1'b1);
		send_char(CH_OPEN, 1'b1);
	endtask

	task automatic test_random_exprs();
		int kind;
		int n;
		int pos;
		while (rand_sent < RAND_ITEMS) begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				build_expr($urandom_range(1, 8));
				send_buf(1'b1);
			end else if (kind < 75) begin
				// nest deep enough to reach and pass a full stack
				n = $urandom_range(12, 20);
				repeat (n) expr_buf.push_back(CH_OPEN);
				build_expr($urandom_range(1, 3));
				repeat ($urandom_range(0, n + 2)) expr_buf.push_back(CH_CLOSE);
				send_buf(1'b1);
			end else if (kind < 90) begin
				// corrupt one character; sometimes carry the stack into the next expression
				build_expr($urandom_range(2, 8));
				pos = $urandom_range(0, expr_buf.size() - 1);
				expr_buf[pos] = CharW'($urandom_range(0, 255));
				send_buf($urandom_range(0, 3) != 0);
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) expr_buf.push_back(CharW'($urandom_range(0, 255)));
				send_buf($urandom_range(0, 1) != 0);
			end
		end
	endtask

	// Result side: stall at random, compare each transfer with the oldest expectation
	initial begin
		int           stall;
		postfix_res_t want;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
			if (postfix_q.size() == 0) begin
				flag_error($sformatf("unexpected result: char=%h none=%b last=%b status=%0d",
					out_char, out_none, out_last, status));
			end else begin
				want = postfix_q.pop_front();
				if (out_char !== want.ch || out_none !== want.none ||
						out_last !== want.last || status !== want.st)
					flag_error($sformatf({"result mismatch: expected char=%h none=%b last=%b ",
						"status=%0d, got char=%h none=%b last=%b status=%0d"},
						want.ch, want.none, want.last, want.st,
						out_char, out_none, out_last, status));
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cyc <= 0;
			else quiet_cyc <= quiet_cyc + 1;
			if (quiet_cyc >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		item_valid  = 1'b0;
		char_in     = '0;
		end_of_expr = 1'b0;
		arst_n      = 1'b0;
		gap_max     = GAP_MAX;
		stall_max   = GAP_MAX;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_char_classes();
		test_precedence();
		test_unmatched_parens();
		test_random_exprs();
		item_valid <= 1'b0;

		// drain, then give any stray result time to show up
		while (postfix_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
